>>> rtl/core/dhow_pkg.sv
// Package for the date/hour offset unit: item types, constants, calendar helpers.
package dhow_pkg;

    // One input item as read from the real-time clock.
    typedef struct packed {
        logic [13:0] in_year;
        logic [3:0]  in_month;
        logic [4:0]  in_day;
        logic [4:0]  in_hour;
    } in_item_t;

    // One result item.
    typedef struct packed {
        logic [13:0] out_year;
        logic [3:0]  out_month;
        logic [4:0]  out_day;
        logic [4:0]  out_hour;
        logic [2:0]  weekday;
    } out_item_t;

    // Shared divide unit operations.
    localparam logic OP_DIV100 = 1'b0;
    localparam logic OP_DIV7   = 1'b1;

    // Reciprocal constants; exact for every operand the sequencer sends, though not for all 16-bit values.
    localparam logic [15:0] DIV100_MUL   = 16'd5243;
    localparam int          DIV100_SHIFT = 19;
    localparam logic [15:0] DIV7_MUL     = 16'd37450;
    localparam int          DIV7_SHIFT   = 18;

    localparam logic [13:0] YEAR_MOD     = 14'd10000;
    localparam logic [13:0] YEAR_LAST    = 14'd9999;
    localparam logic [13:0] YEAR_BIAS    = 14'd400;
    localparam logic [6:0]  HOURS_PER_DAY = 7'd24;

    // Request from the sequencer to the divide unit.
    typedef struct packed {
        logic        start;
        logic        op;
        logic [15:0] operand;
    } div_req_t;

    // Answer of the divide unit, valid for one cycle when done is set.
    typedef struct packed {
        logic        done;
        logic [13:0] quot;
        logic [6:0]  rem;
    } div_rsp_t;

    // Length of a month (1..12) given the leap flag of its year.
    function automatic logic [4:0] days_in(input logic [3:0] month, input logic leap);
        logic [4:0] len;
        begin
            case (month)
                4'd2:                      len = leap ? 5'd29 : 5'd28;
                4'd4, 4'd6, 4'd9, 4'd11:   len = 5'd30;
                default:                   len = 5'd31;
            endcase
            return len;
        end
    endfunction

    // The term 3*(m+1)/5 of the congruence for shifted months 3..14.
    function automatic logic [3:0] month_term(input logic [3:0] wm);
        logic [3:0] t;
        begin
            case (wm)
                4'd3:          t = 4'd2;
                4'd4, 4'd5:    t = 4'd3;
                4'd6, 4'd7:    t = 4'd4;
                4'd8:          t = 4'd5;
                4'd9, 4'd10:   t = 4'd6;
                4'd11, 4'd12:  t = 4'd7;
                4'd13:         t = 4'd8;
                4'd14:         t = 4'd9;
                default:       t = 4'd0;
            endcase
            return t;
        end
    endfunction

endpackage

>>> rtl/core/dhow_div.sv
// Shared two-stage constant divider: quotient and remainder by 100 or by 7.
module dhow_div (
    input  logic              clk,
    input  logic              rst_n,
    input  dhow_pkg::div_req_t req,
    output dhow_pkg::div_rsp_t rsp
);
    import dhow_pkg::*;

    logic        s1_valid_reg;
    logic        s1_op_reg;
    logic [15:0] s1_x_reg;
    logic [31:0] s1_prod_reg;
    logic        done_reg;
    logic [13:0] quot_reg;
    logic [6:0]  rem_reg;

    logic [15:0] mul_k;
    logic [31:0] q_full;
    logic [13:0] q_next;
    logic [15:0] back_prod;
    logic [15:0] rem_full;

    assign mul_k = (req.op == OP_DIV7) ? DIV7_MUL : DIV100_MUL;

    // Second stage: shift out the quotient, then subtract it back out.
    always_comb
    begin
        q_full    = (s1_op_reg == OP_DIV7) ? (s1_prod_reg >> DIV7_SHIFT)
                                           : (s1_prod_reg >> DIV100_SHIFT);
        q_next    = q_full[13:0];
        back_prod = (s1_op_reg == OP_DIV7) ? 16'(q_next * 16'd7)
                                           : 16'(q_next * 16'd100);
        rem_full  = s1_x_reg - back_prod;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            done_reg     <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= req.start;
            done_reg     <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            s1_op_reg   <= req.op;
            s1_x_reg    <= req.operand;
            s1_prod_reg <= req.operand * mul_k;
        end
        if (s1_valid_reg)
        begin
            quot_reg <= q_next;
            rem_reg  <= rem_full[6:0];
        end
    end

    assign rsp.done = done_reg;
    assign rsp.quot = quot_reg;
    assign rsp.rem  = rem_reg;

endmodule

>>> rtl/core/dhow_seq.sv
// Sequencer and date registers: leap test, hour carry/borrow steps, weekday.
module dhow_seq (
    input  logic                clk,
    input  logic                rst_n,
    input  logic signed [5:0]   hour_offset,
    input  logic                src_valid,
    output logic                src_stall,
    input  dhow_pkg::in_item_t  src_item,
    input  logic                res_free,
    output logic                res_load,
    output dhow_pkg::out_item_t res_data,
    output dhow_pkg::div_req_t  div_req,
    input  dhow_pkg::div_rsp_t  div_rsp
);
    import dhow_pkg::*;

    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_LEAP_REQ = 4'd1;
    localparam logic [3:0] S_LEAP_WT  = 4'd2;
    localparam logic [3:0] S_CLAMP    = 4'd3;
    localparam logic [3:0] S_STEP     = 4'd4;
    localparam logic [3:0] S_WD_REQ   = 4'd5;
    localparam logic [3:0] S_WD_WT    = 4'd6;
    localparam logic [3:0] S_MOD_REQ  = 4'd7;
    localparam logic [3:0] S_MOD_WT   = 4'd8;
    localparam logic [3:0] S_DONE     = 4'd9;

    logic [3:0]         state_reg, state_next;
    logic [13:0]        y_reg, y_next;
    logic [3:0]         m_reg, m_next;
    logic [4:0]         d_reg, d_next;
    logic signed [6:0]  h_reg, h_next;
    logic               leap_reg, leap_next;
    logic [3:0]         wm_reg, wm_next;
    logic [13:0]        wy_reg, wy_next;
    logic [15:0]        sum_reg, sum_next;
    logic [2:0]         wd_reg, wd_next;

    logic [4:0]         md;
    logic [4:0]         md_prev;
    logic signed [6:0]  h_in;
    logic               early;

    assign md      = days_in(m_reg, leap_reg);
    assign md_prev = days_in(4'(m_reg - 4'd1), leap_reg);
    assign h_in    = signed'({2'b00, src_item.in_hour}) + 7'(hour_offset);
    assign early   = (m_reg <= 4'd2);

    always_comb
    begin
        state_next = state_reg;
        y_next     = y_reg;
        m_next     = m_reg;
        d_next     = d_reg;
        h_next     = h_reg;
        leap_next  = leap_reg;
        wm_next    = wm_reg;
        wy_next    = wy_reg;
        sum_next   = sum_reg;
        wd_next    = wd_reg;
        div_req    = '0;
        res_load   = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (src_valid)
                begin
                    y_next = (src_item.in_year >= YEAR_MOD) ? src_item.in_year - YEAR_MOD
                                                            : src_item.in_year;
                    if (src_item.in_month == 4'd0)
                        m_next = 4'd1;
                    else if (src_item.in_month > 4'd12)
                        m_next = 4'd12;
                    else
                        m_next = src_item.in_month;
                    d_next     = (src_item.in_day == 5'd0) ? 5'd1 : src_item.in_day;
                    h_next     = h_in;
                    state_next = S_LEAP_REQ;
                end
            end
            S_LEAP_REQ:
            begin
                div_req.start   = 1'b1;
                div_req.op      = OP_DIV100;
                div_req.operand = {2'b00, y_reg};
                state_next      = S_LEAP_WT;
            end
            S_LEAP_WT:
            begin
                if (div_rsp.done)
                begin
                    // Divisible by 400 means divisible by 100 with a quotient divisible by 4.
                    leap_next  = (div_rsp.rem == 7'd0) ? (div_rsp.quot[1:0] == 2'b00)
                                                       : (y_reg[1:0] == 2'b00);
                    state_next = S_CLAMP;
                end
            end
            S_CLAMP:
            begin
                if (d_reg > md)
                    d_next = md;
                state_next = S_STEP;
            end
            S_STEP:
            begin
                if (h_reg >= signed'(HOURS_PER_DAY))
                begin
                    h_next = h_reg - signed'(HOURS_PER_DAY);
                    if (d_reg >= md)
                    begin
                        d_next = 5'd1;
                        if (m_reg >= 4'd12)
                        begin
                            m_next     = 4'd1;
                            y_next     = (y_reg >= YEAR_LAST) ? 14'd0 : y_reg + 14'd1;
                            state_next = S_LEAP_REQ;
                        end
                        else
                        begin
                            m_next = m_reg + 4'd1;
                        end
                    end
                    else
                    begin
                        d_next = d_reg + 5'd1;
                    end
                end
                else if (h_reg < 7'sd0)
                begin
                    h_next = h_reg + signed'(HOURS_PER_DAY);
                    if (d_reg <= 5'd1)
                    begin
                        if (m_reg <= 4'd1)
                        begin
                            m_next     = 4'd12;
                            d_next     = 5'd31;
                            y_next     = (y_reg == 14'd0) ? YEAR_LAST : y_reg - 14'd1;
                            state_next = S_LEAP_REQ;
                        end
                        else
                        begin
                            m_next = m_reg - 4'd1;
                            d_next = md_prev;
                        end
                    end
                    else
                    begin
                        d_next = d_reg - 5'd1;
                    end
                end
                else
                begin
                    state_next = S_WD_REQ;
                end
            end
            S_WD_REQ:
            begin
                wm_next         = early ? m_reg + 4'd12 : m_reg;
                wy_next         = y_reg + YEAR_BIAS - {13'd0, early};
                div_req.start   = 1'b1;
                div_req.op      = OP_DIV100;
                div_req.operand = {2'b00, y_reg + YEAR_BIAS - {13'd0, early}};
                state_next      = S_WD_WT;
            end
            S_WD_WT:
            begin
                if (div_rsp.done)
                begin
                    sum_next = 16'(d_reg) + {11'd0, wm_reg, 1'b0}
                             + 16'(month_term(wm_reg))
                             + 16'(wy_reg) + 16'(wy_reg >> 2)
                             - 16'(div_rsp.quot) + 16'(div_rsp.quot >> 2);
                    state_next = S_MOD_REQ;
                end
            end
            S_MOD_REQ:
            begin
                div_req.start   = 1'b1;
                div_req.op      = OP_DIV7;
                div_req.operand = sum_reg;
                state_next      = S_MOD_WT;
            end
            S_MOD_WT:
            begin
                if (div_rsp.done)
                begin
                    wd_next    = div_rsp.rem[2:0];
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (res_free)
                begin
                    res_load   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    always_ff @(posedge clk)
    begin
        y_reg    <= y_next;
        m_reg    <= m_next;
        d_reg    <= d_next;
        h_reg    <= h_next;
        leap_reg <= leap_next;
        wm_reg   <= wm_next;
        wy_reg   <= wy_next;
        sum_reg  <= sum_next;
        wd_reg   <= wd_next;
    end

    assign src_stall          = (state_reg != S_IDLE);
    assign res_data.out_year  = y_reg;
    assign res_data.out_month = m_reg;
    assign res_data.out_day   = d_reg;
    assign res_data.out_hour  = h_reg[4:0];
    assign res_data.weekday   = wd_reg;

endmodule

>>> rtl/core/date_hour_offset_weekday_unit.sv
// Top level of the date/hour offset unit with day-of-week output.
//
//  Channel   Signals                          Direction  Accepted when
//  src       src_valid, src_stall, src_item   in         src_valid && !src_stall
//  res       res_valid, res_stall, res_item   out        res_valid && !res_stall
//  cfg       cfg_wr_en, cfg_wr_data           in         cfg_wr_en (no wait)
//
// Once an item is accepted, the sequencer works on it until its result is loaded into
// the output register, when that register is free. The work is set by the sequencer's
// use of the single two-stage divide unit, which is run for the leap-year test, again
// after a year change, and twice for the day of the week, plus one step per day of
// carry or borrow (at most two days).
// Reset clears the sequencer and the output valid flag and sets the hour offset to zero.
// The input side is stalled while an item is in progress. A finished result waits in
// the output register, so the next item can be taken while the result is stalled.
module date_hour_offset_weekday_unit (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_wr_en,
    input  logic signed [5:0]   cfg_wr_data,
    input  logic                src_valid,
    output logic                src_stall,
    input  dhow_pkg::in_item_t  src_item,
    output logic                res_valid,
    input  logic                res_stall,
    output dhow_pkg::out_item_t res_item
);
    import dhow_pkg::*;

    logic signed [5:0] hour_offset_reg;
    logic              res_valid_reg;
    out_item_t         res_item_reg;

    logic              res_free;
    logic              res_load;
    out_item_t         res_data;
    div_req_t          div_req;
    div_rsp_t          div_rsp;

    // The output register can take a new result when it is empty or being drained.
    assign res_free = !res_valid_reg || !res_stall;

    dhow_seq u_seq (
        .clk         (clk),
        .rst_n       (rst_n),
        .hour_offset (hour_offset_reg),
        .src_valid   (src_valid),
        .src_stall   (src_stall),
        .src_item    (src_item),
        .res_free    (res_free),
        .res_load    (res_load),
        .res_data    (res_data),
        .div_req     (div_req),
        .div_rsp     (div_rsp)
    );

    dhow_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    // Offset register; the user must write it only while no item is in flight, the block does not enforce this.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            hour_offset_reg <= 6'sd0;
        else if (cfg_wr_en)
            hour_offset_reg <= cfg_wr_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            res_valid_reg <= 1'b0;
        else if (res_load)
            res_valid_reg <= 1'b1;
        else if (!res_stall)
            res_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (res_load)
            res_item_reg <= res_data;
    end

    assign res_valid = res_valid_reg;
    assign res_item  = res_item_reg;

endmodule

>>> bench/date_hour_offset_weekday_unit_chk.sv
`timescale 1ns / 1ps
// Checker for the date/hour offset unit: predicts each adjusted date and compares results.
module date_hour_offset_weekday_unit_chk (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_wr_en,
    input  logic signed [5:0]   cfg_wr_data,
    input  logic                src_valid,
    input  logic                src_stall,
    input  dhow_pkg::in_item_t  src_item,
    input  logic                res_valid,
    input  logic                res_stall,
    input  dhow_pkg::out_item_t res_item,
    output int                  mismatch_count,
    output int                  pending_count
);
    import dhow_pkg::*;

    logic signed [5:0] zone_offset = 6'sd0;
    out_item_t         expected_dates[$];
    out_item_t         want;
    int                errors_seen = 0;
    int                dates_waiting = 0;

    assign mismatch_count = errors_seen;
    assign pending_count  = dates_waiting;

    function automatic bit is_leap_year(input int y);
        if (y % 100 == 0)
            return (y % 400) == 0;
        return (y % 4) == 0;
    endfunction

    function automatic int month_length(input int m, input int y);
        case (m)
            2:             return is_leap_year(y) ? 29 : 28;
            4, 6, 9, 11:   return 30;
            default:       return 31;
        endcase
    endfunction

    // Adds the zone offset to one clock reading and works out the weekday.
    function automatic out_item_t shift_reading(input in_item_t rd,
                                                input logic signed [5:0] off);
        int        y;
        int        m;
        int        d;
        int        h;
        int        wm;
        int        wy;
        int        w;
        out_item_t res;
        begin
            y = int'(rd.in_year) % 10000;
            m = int'(rd.in_month);
            d = int'(rd.in_day);
            h = int'(rd.in_hour) + int'(off);
            if (m < 1) m = 1;
            if (m > 12) m = 12;
            if (d < 1) d = 1;
            if (d > month_length(m, y)) d = month_length(m, y);

            // Large sums can carry or borrow across up to two days.
            while (h >= 24) begin
                h = h - 24;
                d = d + 1;
                if (d > month_length(m, y)) begin
                    d = d - month_length(m, y);
                    m = m + 1;
                    if (m > 12) begin
                        m = 1;
                        y = (y >= 9999) ? 0 : y + 1;
                    end
                end
            end
            while (h < 0) begin
                h = h + 24;
                d = d - 1;
                if (d < 1) begin
                    m = m - 1;
                    if (m < 1) begin
                        m = 12;
                        y = (y <= 0) ? 9999 : y - 1;
                    end
                    d = d + month_length(m, y);
                end
            end

            // January and February count as months 13 and 14 of the year before.
            wm = m;
            wy = y + 400;
            if (wm <= 2) begin
                wm = wm + 12;
                wy = wy - 1;
            end
            w = (d + 2 * wm + (3 * (wm + 1)) / 5 + wy + wy / 4 - wy / 100 + wy / 400) % 7;

            res.out_year  = 14'(y);
            res.out_month = 4'(m);
            res.out_day   = 5'(d);
            res.out_hour  = 5'(h);
            res.weekday   = 3'(w);
            return res;
        end
    endfunction

    task automatic report_mismatch(input string msg);
        begin
            $display("%0t ns: mismatch: %s", $time, msg);
            errors_seen++;
        end
    endtask

    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            zone_offset = 6'sd0;
            expected_dates.delete();
            dates_waiting = 0;
        end else begin
            if (res_valid && !res_stall) begin
                if (expected_dates.size() == 0) begin
                    report_mismatch($sformatf("result %0d-%0d-%0d h%0d with no item outstanding",
                        res_item.out_year, res_item.out_month, res_item.out_day,
                        res_item.out_hour));
                end else begin
                    want = expected_dates.pop_front();
                    if (res_item.out_year !== want.out_year)
                        report_mismatch($sformatf("year got %0d expected %0d",
                            res_item.out_year, want.out_year));
                    if (res_item.out_month !== want.out_month)
                        report_mismatch($sformatf("month got %0d expected %0d",
                            res_item.out_month, want.out_month));
                    if (res_item.out_day !== want.out_day)
                        report_mismatch($sformatf("day got %0d expected %0d",
                            res_item.out_day, want.out_day));
                    if (res_item.out_hour !== want.out_hour)
                        report_mismatch($sformatf("hour got %0d expected %0d",
                            res_item.out_hour, want.out_hour));
                    if (res_item.weekday !== want.weekday)
                        report_mismatch($sformatf("weekday got %0d expected %0d",
                            res_item.weekday, want.weekday));
                end
            end
            if (src_valid && !src_stall)
                expected_dates.push_back(shift_reading(src_item, zone_offset));
            if (cfg_wr_en)
                zone_offset = cfg_wr_data;
            dates_waiting = expected_dates.size();
        end
    end

endmodule

>>> bench/date_hour_offset_weekday_unit_tb.sv
`timescale 1ns / 1ps
// Testbench top for the date/hour offset unit: clock, reset, stimulus and verdict.
module date_hour_offset_weekday_unit_tb;
    import dhow_pkg::*;

    // Number of random phases; each one starts with a fresh zone offset.
    localparam int PHASES          = 10;
    localparam int ITEMS_PER_PHASE = 173;
    // Cycles allowed after the last result so that a stray extra result is seen.
    localparam int TAIL_CYCLES     = 40;

    logic              clk         = 1'b0;
    logic              rst_n       = 1'b0;
    logic              cfg_wr_en   = 1'b0;
    logic signed [5:0] cfg_wr_data = 6'sd0;
    logic              src_valid   = 1'b0;
    logic              src_stall;
    in_item_t          src_item    = '0;
    logic              res_valid;
    logic              res_stall   = 1'b0;
    out_item_t         res_item;

    int mismatch_count;
    int pending_count;

    // Percent chance per item of a sender gap, and per cycle of a receiver stall.
    int gap_pct   = 0;
    int stall_pct = 0;

    // Fixed offsets for the first phases: both ends of the time zone range, the
    // smallest steps each way, zero, both ends of the 6-bit register, and 12.
    int phase_offsets[8] = '{24, -24, -1, 1, 0, -32, 31, 12};

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    date_hour_offset_weekday_unit u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .src_valid   (src_valid),
        .src_stall   (src_stall),
        .src_item    (src_item),
        .res_valid   (res_valid),
        .res_stall   (res_stall),
        .res_item    (res_item)
    );

    date_hour_offset_weekday_unit_chk u_chk (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_wr_data    (cfg_wr_data),
        .src_valid      (src_valid),
        .src_stall      (src_stall),
        .src_item       (src_item),
        .res_valid      (res_valid),
        .res_stall      (res_stall),
        .res_item       (res_item),
        .mismatch_count (mismatch_count),
        .pending_count  (pending_count)
    );

    function automatic in_item_t reading(input int y, input int m, input int d, input int h);
        in_item_t it;
        begin
            it.in_year  = 14'(y);
            it.in_month = 4'(m);
            it.in_day   = 5'(d);
            it.in_hour  = 5'(h);
            return it;
        end
    endfunction

    // A clock reading that is usually well formed and often sits on a month,
    // year or century boundary, with a share of out-of-range fields mixed in.
    function automatic in_item_t random_reading();
        int y;
        int m;
        int d;
        int h;
        int len;
        int pick;
        begin
            pick = $urandom_range(0, 99);
            if (pick < 65)
                y = $urandom_range(1, 9998);
            else if (pick < 85) begin
                case ($urandom_range(0, 5))
                    0:       y = 0;
                    1:       y = 9999;
                    2:       y = $urandom_range(1, 3);
                    3:       y = $urandom_range(9996, 9998);
                    4:       y = 100 * $urandom_range(0, 99);
                    default: y = 4 * $urandom_range(0, 2499);
                endcase
            end else
                y = $urandom_range(0, 16383);

            if ($urandom_range(0, 19) == 0)
                m = $urandom_range(0, 15);
            else
                m = $urandom_range(1, 12);

            // Month length of the clamped month, leap years included.
            case ((m < 1) ? 1 : ((m > 12) ? 12 : m))
                2: begin
                    if ((y % 10000) % 100 == 0)
                        len = ((y % 10000) % 400 == 0) ? 29 : 28;
                    else
                        len = ((y % 10000) % 4 == 0) ? 29 : 28;
                end
                4, 6, 9, 11: len = 30;
                default:     len = 31;
            endcase

            pick = $urandom_range(0, 19);
            if (pick == 0)
                d = $urandom_range(0, 31);
            else if (pick <= 6)
                d = len - $urandom_range(0, 1);
            else if (pick <= 9)
                d = 1 + $urandom_range(0, 1);
            else
                d = $urandom_range(1, len);

            pick = $urandom_range(0, 15);
            if (pick == 0)
                h = $urandom_range(0, 31);
            else if (pick <= 3)
                h = ($urandom_range(0, 1) == 1) ? 23 : 0;
            else
                h = $urandom_range(0, 23);

            return reading(y, m, d, h);
        end
    endfunction

    // Offers one item and returns at the clock edge where it is taken. A random
    // gap before the item drops valid first; otherwise valid simply stays high.
    task automatic send_reading(input in_item_t it);
        begin
            if ($urandom_range(1, 100) <= gap_pct) begin
                src_valid <= 1'b0;
                repeat ($urandom_range(1, 18)) @(posedge clk);
            end
            src_valid <= 1'b1;
            src_item  <= it;
            do
                @(posedge clk);
            while (src_stall);
        end
    endtask

    // Blocks until every expected result has arrived; the count is sampled on
    // the falling edge so that it never races the checker's update.
    task automatic wait_for_results();
        begin
            do
                @(negedge clk);
            while (pending_count != 0);
        end
    endtask

    // Changes the zone offset only while the unit is idle. Each item gives a
    // result, so an empty queue means nothing is in flight; a few extra cycles
    // are added anyway before the write.
    task automatic write_offset(input int value);
        begin
            src_valid <= 1'b0;
            wait_for_results();
            repeat (4) @(posedge clk);
            cfg_wr_en   <= 1'b1;
            cfg_wr_data <= 6'(value);
            @(posedge clk);
            cfg_wr_en   <= 1'b0;
        end
    endtask

    // Receiver: stalls come in random bursts at a rate the stimulus sets per phase.
    initial begin
        wait (rst_n === 1'b1);
        forever begin
            @(posedge clk);
            if ($urandom_range(1, 100) <= stall_pct) begin
                res_stall <= 1'b1;
                repeat ($urandom_range(1, 18)) @(posedge clk);
                res_stall <= 1'b0;
            end
        end
    end

    // Stimulus and verdict.
    initial begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part, offset zero from reset: field extremes and the
        // out-of-range cases that get clamped or reduced.
        gap_pct   = 20;
        stall_pct = 10;
        send_reading(reading(1, 1, 1, 0));
        send_reading(reading(9998, 12, 31, 23));
        send_reading(reading(16383, 7, 15, 12));   // year above 9999 is reduced
        send_reading(reading(2023, 0, 10, 5));     // month zero taken as January
        send_reading(reading(2023, 15, 10, 5));    // high months taken as December
        send_reading(reading(2023, 6, 0, 5));      // day zero taken as the first
        send_reading(reading(2023, 2, 31, 5));     // day saturates to the month length
        send_reading(reading(2024, 4, 31, 31));    // hour past 23 carries on its own

        // Largest positive offset: multi-day carries, leap rules, year wrap.
        write_offset(31);
        send_reading(reading(9999, 12, 31, 31));   // carries out of 9999 into year 0
        send_reading(reading(2024, 2, 28, 23));    // leap year by four
        send_reading(reading(1900, 2, 28, 23));    // century that is not leap
        send_reading(reading(2000, 2, 28, 23));    // leap year by four hundred
        send_reading(reading(2023, 1, 31, 20));
        send_reading(reading(2023, 4, 30, 0));

        // Most negative offset: borrows back across months and years.
        write_offset(-32);
        send_reading(reading(0, 1, 1, 0));         // borrows out of year 0 into 9999
        send_reading(reading(2024, 3, 1, 0));
        send_reading(reading(2100, 3, 1, 5));
        send_reading(reading(2023, 0, 0, 0));
        send_reading(reading(10000, 1, 1, 8));     // reduces to year 0
        send_reading(reading(1, 1, 1, 31));

        // Random part. Every third phase runs without idling, and the last
        // phase has no idling at all.
        for (int p = 0; p < PHASES; p++) begin
            if (p < 8)
                write_offset(phase_offsets[p]);
            else
                write_offset(int'($urandom_range(0, 63)) - 32);
            if (p == PHASES - 1 || p % 3 == 0) begin
                gap_pct   = 0;
                stall_pct = 0;
            end else begin
                gap_pct   = $urandom_range(5, 40);
                stall_pct = $urandom_range(2, 15);
            end
            for (int i = 0; i < ITEMS_PER_PHASE; i++)
                send_reading(random_reading());
        end

        src_valid <= 1'b0;
        wait_for_results();
        repeat (TAIL_CYCLES) @(posedge clk);
        @(negedge clk);
        if (mismatch_count == 0)
            $display("[date_hour_offset_weekday_unit] OK");
        else
            $display("[date_hour_offset_weekday_unit] ERROR");
        $finish;
    end

    // Watchdog: far longer than the slowest correct run takes.
    initial begin
        #6000000;
        $display("[date_hour_offset_weekday_unit] ERROR");
        $finish;
    end

endmodule
